>>> rtl/core/lhm_pkg.sv
`timescale 1ns / 1ps

package lhm_pkg;

    localparam int DATA_W = 32;
    localparam int VAL_W  = 48;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int MOD_STEPS = VAL_W;

    // Bound on the offset from the low edge before it is scaled.
    localparam logic signed [PROD_W-1:0] DIFF_LIMIT = 66'sd70368744177664;
    // Bound on the lagged bin before it is scaled by the bin width.
    localparam logic signed [VAL_W-1:0]  BJ_LIMIT   = 48'sd1073741824;

    localparam logic signed [31:0] RANGE_LOW_RST = 32'sd0;
    localparam logic [31:0]        BIN_WIDTH_RST = 32'd65536;
    localparam logic [31:0]        INV_WIDTH_RST = 32'd65536;
    localparam logic [6:0]         NUM_BINS_RST  = 7'd50;
    localparam logic [10:0]        LAG_RST       = 11'd1;

    typedef enum logic [2:0] {
        CMD_SAMPLE     = 3'd0,
        CMD_NEW_TRAJ   = 3'd1,
        CMD_SYMMETRIZE = 3'd2,
        CMD_READ       = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_RANGE_LOW   = 3'd0,
        REG_BIN_WIDTH   = 3'd1,
        REG_INV_WIDTH   = 3'd2,
        REG_NUM_BINS    = 3'd3,
        REG_LAG         = 3'd4,
        REG_CENTRE_MODE = 3'd5,
        REG_PERIODIC    = 3'd6
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DLY_RD,
        ST_DSAT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_BIN,
        ST_CTR_MUL,
        ST_CTR_ADD,
        ST_WRAP,
        ST_MODJ_GO,
        ST_MODJ_WAIT,
        ST_MODI_GO,
        ST_MODI_WAIT,
        ST_MAT_RD,
        ST_MAT_INC,
        ST_RD_DATA,
        ST_SYM_RA,
        ST_SYM_RB,
        ST_SYM_WA,
        ST_SYM_WB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] value;
    } mod_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_rsp_t;

endpackage

>>> rtl/core/lhm_ram.sv
`timescale 1ns / 1ps

module lhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/lhm_mul.sv
`timescale 1ns / 1ps

module lhm_mul (
    input  logic                              clk,
    input  logic signed [lhm_pkg::MUL_W-1:0]  a,
    input  logic signed [lhm_pkg::MUL_W-1:0]  b,
    output logic signed [lhm_pkg::PROD_W-1:0] prod
);

    logic signed [lhm_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/lhm_mod.sv
`timescale 1ns / 1ps

module lhm_mod #(
    parameter int NB_W = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lhm_pkg::mod_req_t   req,
    input  logic [NB_W-1:0]     modulus,
    output lhm_pkg::mod_rsp_t   rsp,
    output logic [NB_W-1:0]     remainder
);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [lhm_pkg::VAL_W-1:0]   mag_reg;
    logic [NB_W-1:0]             rem_reg;
    logic [NB_W-1:0]             n_reg;
    logic [5:0]                  step_reg;
    logic [NB_W:0]               trial;
    logic [NB_W-1:0]             rem_next;

    // One quotient bit per cycle, restoring style; only the remainder is kept.
    always_comb begin
        trial = {rem_reg, mag_reg[lhm_pkg::VAL_W-1]};
        if (trial >= {1'b0, n_reg}) begin
            rem_next = NB_W'(trial - {1'b0, n_reg});
        end else begin
            rem_next = trial[NB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg  <= req.value[lhm_pkg::VAL_W-1];
            mag_reg  <= req.value[lhm_pkg::VAL_W-1] ? -req.value : req.value;
            rem_reg  <= '0;
            n_reg    <= modulus;
            step_reg <= 6'(lhm_pkg::MOD_STEPS - 1);
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            mag_reg  <= {mag_reg[lhm_pkg::VAL_W-2:0], 1'b0};
            step_reg <= step_reg - 6'd1;
        end
    end

    // A negative input folds back into the range from zero to the modulus.
    assign remainder = (neg_reg && rem_reg != '0) ? n_reg - rem_reg : rem_reg;
    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;

endmodule

>>> rtl/core/lagged_transition_histogram.sv
`timescale 1ns / 1ps

// Lagged transition histogram: each sample word is paired with the sample lag
// words earlier in the same trajectory, and when both carry the include flag
// the pair is binned and, if both bins are in range, count[current][lagged]
// is incremented, saturating; other command words start a trajectory,
// symmetrize, read or clear the matrix, and every word gives exactly one
// result word. The block works on one word at a time and s_ready is low while
// it does. A binned sample makes two passes through the shared 33x33
// multiplier (two partial products per bin), plus a centring product when
// centring; when periodic, each bin is then reduced modulo num_bins by a
// bit-serial remainder unit (48 steps). Symmetrize reads and writes each entry
// pair in turn through the matrix RAM. Clear and the pass after reset each
// sweep the whole matrix RAM, one entry per cycle, over its
// (2**clog2(MAX_BINS))**2 entries (4096 at the default size); no word is taken
// meanwhile, while configuration writes go through.
module lagged_transition_histogram #(
    parameter int MAX_BINS = 64,
    parameter int MAX_LAG  = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic signed [31:0] s_sample_value,
    input  logic               s_include_flag,
    input  logic [5:0]         s_read_row,
    input  logic [5:0]         s_read_column,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_count,
    output logic               m_binned,
    output logic [5:0]         m_current_bin,
    output logic [5:0]         m_lagged_bin
);

    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int NB_W      = BIN_W + 1;
    localparam int MAT_AW    = 2 * BIN_W;
    localparam int MAT_DEPTH = 1 << MAT_AW;
    localparam int PTR_W     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int LAG_W     = $clog2(MAX_LAG + 1);
    localparam int DLY_W     = lhm_pkg::DATA_W + 1;
    localparam int VAL_W     = lhm_pkg::VAL_W;
    localparam int PROD_W    = lhm_pkg::PROD_W;

    lhm_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic signed [31:0] range_low_reg;
    logic [31:0]        bin_width_reg;
    logic [31:0]        inv_width_reg;
    logic [6:0]         num_bins_reg;
    logic [10:0]        lag_reg;
    logic               centre_mode_reg;
    logic               periodic_reg;

    // Control state.
    logic [PTR_W-1:0]   dly_ptr_reg;
    logic [LAG_W-1:0]   fill_reg;
    logic [MAT_AW-1:0]  clr_cnt_reg;
    logic               clr_cmd_reg;
    logic               m_valid_reg;

    // Output word.
    logic [31:0]        m_count_reg;
    logic               m_binned_reg;
    logic [5:0]         m_cur_reg;
    logic [5:0]         m_lag_reg;

    // Working registers of the sequencer.
    logic [PTR_W-1:0]          p_reg;
    logic signed [31:0]        qi_reg;
    logic                      xi_reg;
    logic signed [32:0]        diff_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [VAL_W-1:0]   d_reg;
    logic [55:0]               lo_reg;
    logic signed [VAL_W-1:0]   bj_reg;
    logic signed [VAL_W-1:0]   bi_reg;
    logic                      phase_reg;
    logic [31:0]               cnt_reg;
    logic                      binned_reg;
    logic                      rd_ok_reg;
    logic [BIN_W-1:0]          sym_i_reg;
    logic [BIN_W-1:0]          sym_j_reg;
    logic [31:0]               sym_a_reg;
    logic [31:0]               sym_sum_reg;

    // Combinational signals.
    logic                      s_accept;
    logic                      out_load;
    logic [LAG_W-1:0]          lag_eff;
    logic [NB_W-1:0]           nb_eff;
    logic [PTR_W-1:0]          p_comb;
    logic                      filling;
    logic [DLY_W-1:0]          dly_rdata;
    logic signed [31:0]        qj;
    logic                      xj;
    logic [31:0]               mat_rdata;
    logic signed [79:0]        bin_full;
    logic signed [VAL_W-1:0]   bin_val;
    logic signed [PROD_W-1:0]  acc_clamp;
    logic signed [VAL_W-1:0]   bc_wide;
    logic signed [31:0]        bc;
    logic signed [lhm_pkg::MUL_W-1:0] mul_a;
    logic signed [lhm_pkg::MUL_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    lhm_pkg::mod_req_t         mod_req;
    lhm_pkg::mod_rsp_t         mod_rsp;
    logic [NB_W-1:0]           mod_rem;
    logic                      in_range;
    logic                      sym_last;
    logic [31:0]               inc_val;
    logic [32:0]               sym_raw;
    logic [31:0]               sym_sum;
    logic                      mat_we;
    logic [MAT_AW-1:0]         mat_waddr;
    logic [31:0]               mat_wdata;
    logic [MAT_AW-1:0]         mat_raddr;
    logic                      dly_we;
    logic [PTR_W-1:0]          dly_waddr;
    logic [DLY_W-1:0]          dly_wdata;
    logic [PTR_W-1:0]          dly_raddr;

    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == lhm_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    // Out-of-range settings are pulled into the supported range.
    always_comb begin
        if (lag_reg == '0) begin
            lag_eff = LAG_W'(1);
        end else if (int'(lag_reg) > MAX_LAG) begin
            lag_eff = LAG_W'(MAX_LAG);
        end else begin
            lag_eff = LAG_W'(lag_reg);
        end
        if (num_bins_reg == '0) begin
            nb_eff = NB_W'(1);
        end else if (int'(num_bins_reg) > MAX_BINS) begin
            nb_eff = NB_W'(MAX_BINS);
        end else begin
            nb_eff = NB_W'(num_bins_reg);
        end
    end

    // A pointer left past a shortened lag restarts at the head of the line.
    assign p_comb  = (LAG_W'(dly_ptr_reg) >= lag_eff) ? '0 : dly_ptr_reg;
    assign filling = fill_reg < lag_eff;

    assign qj = $signed(dly_rdata[31:0]);
    assign xj = dly_rdata[32];

    // The bin is the integer part of the Q32.32 product of offset and
    // reciprocal width; the offset is split in two 24-bit halves.
    assign bin_full = (80'(prod) <<< 24) + $signed({24'b0, lo_reg});
    assign bin_val  = bin_full[79:32];

    always_comb begin
        if (acc_reg > lhm_pkg::DIFF_LIMIT) begin
            acc_clamp = lhm_pkg::DIFF_LIMIT;
        end else if (acc_reg < -lhm_pkg::DIFF_LIMIT) begin
            acc_clamp = -lhm_pkg::DIFF_LIMIT;
        end else begin
            acc_clamp = acc_reg;
        end
        if (bj_reg > lhm_pkg::BJ_LIMIT) begin
            bc_wide = lhm_pkg::BJ_LIMIT;
        end else if (bj_reg < -lhm_pkg::BJ_LIMIT) begin
            bc_wide = -lhm_pkg::BJ_LIMIT;
        end else begin
            bc_wide = bj_reg;
        end
        bc = bc_wide[31:0];
    end

    assign in_range = !bi_reg[VAL_W-1] && !bj_reg[VAL_W-1]
                      && (bi_reg < $signed({{(VAL_W-NB_W){1'b0}}, nb_eff}))
                      && (bj_reg < $signed({{(VAL_W-NB_W){1'b0}}, nb_eff}));

    assign sym_last = (NB_W'(sym_i_reg) + NB_W'(1) == nb_eff)
                      && (NB_W'(sym_j_reg) + NB_W'(1) == nb_eff);

    assign inc_val = (&mat_rdata) ? mat_rdata : mat_rdata + 32'd1;
    assign sym_raw = {1'b0, sym_a_reg} + {1'b0, mat_rdata};
    assign sym_sum = sym_raw[32] ? '1 : sym_raw[31:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lhm_pkg::ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = clr_cmd_reg ? lhm_pkg::ST_OUT : lhm_pkg::ST_IDLE;
                end
            end
            lhm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (lhm_pkg::cmd_t'(s_cmd))
                        lhm_pkg::CMD_SAMPLE:     state_next = lhm_pkg::ST_DLY_RD;
                        lhm_pkg::CMD_SYMMETRIZE: state_next = lhm_pkg::ST_SYM_RA;
                        lhm_pkg::CMD_READ:       state_next = lhm_pkg::ST_RD_DATA;
                        lhm_pkg::CMD_CLEAR:      state_next = lhm_pkg::ST_CLEAR;
                        default:                 state_next = lhm_pkg::ST_OUT;
                    endcase
                end
            end
            lhm_pkg::ST_DLY_RD: begin
                if (filling || !(xi_reg && xj)) begin
                    state_next = lhm_pkg::ST_OUT;
                end else begin
                    state_next = lhm_pkg::ST_DSAT;
                end
            end
            lhm_pkg::ST_DSAT:   state_next = lhm_pkg::ST_MUL_LO;
            lhm_pkg::ST_MUL_LO: state_next = lhm_pkg::ST_MUL_HI;
            lhm_pkg::ST_MUL_HI: state_next = lhm_pkg::ST_BIN;
            lhm_pkg::ST_BIN: begin
                if (phase_reg) begin
                    state_next = lhm_pkg::ST_WRAP;
                end else if (centre_mode_reg) begin
                    state_next = lhm_pkg::ST_CTR_MUL;
                end else begin
                    state_next = lhm_pkg::ST_DSAT;
                end
            end
            lhm_pkg::ST_CTR_MUL: state_next = lhm_pkg::ST_CTR_ADD;
            lhm_pkg::ST_CTR_ADD: state_next = lhm_pkg::ST_DSAT;
            lhm_pkg::ST_WRAP: begin
                if (periodic_reg) begin
                    state_next = lhm_pkg::ST_MODJ_GO;
                end else if (in_range) begin
                    state_next = lhm_pkg::ST_MAT_RD;
                end else begin
                    state_next = lhm_pkg::ST_OUT;
                end
            end
            lhm_pkg::ST_MODJ_GO: state_next = lhm_pkg::ST_MODJ_WAIT;
            lhm_pkg::ST_MODJ_WAIT: begin
                if (mod_rsp.done) begin
                    state_next = lhm_pkg::ST_MODI_GO;
                end
            end
            lhm_pkg::ST_MODI_GO: state_next = lhm_pkg::ST_MODI_WAIT;
            lhm_pkg::ST_MODI_WAIT: begin
                if (mod_rsp.done) begin
                    state_next = lhm_pkg::ST_MAT_RD;
                end
            end
            lhm_pkg::ST_MAT_RD:  state_next = lhm_pkg::ST_MAT_INC;
            lhm_pkg::ST_MAT_INC: state_next = lhm_pkg::ST_OUT;
            lhm_pkg::ST_RD_DATA: state_next = lhm_pkg::ST_OUT;
            lhm_pkg::ST_SYM_RA:  state_next = lhm_pkg::ST_SYM_RB;
            lhm_pkg::ST_SYM_RB:  state_next = lhm_pkg::ST_SYM_WA;
            lhm_pkg::ST_SYM_WA:  state_next = lhm_pkg::ST_SYM_WB;
            lhm_pkg::ST_SYM_WB: begin
                state_next = sym_last ? lhm_pkg::ST_OUT : lhm_pkg::ST_SYM_RA;
            end
            lhm_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = lhm_pkg::ST_IDLE;
                end
            end
            default: state_next = lhm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory ports, multiplier operands and the
    // remainder unit request.
    always_comb begin
        s_ready       = 1'b0;
        mat_we        = 1'b0;
        mat_waddr     = clr_cnt_reg;
        mat_wdata     = '0;
        mat_raddr     = {BIN_W'(s_read_row), BIN_W'(s_read_column)};
        dly_we        = 1'b0;
        dly_waddr     = p_reg;
        dly_wdata     = {xi_reg, qi_reg};
        dly_raddr     = p_comb;
        mul_a         = '0;
        mul_b         = '0;
        mod_req.start = 1'b0;
        mod_req.value = bj_reg;
        unique case (state_reg)
            lhm_pkg::ST_IDLE:  s_ready = 1'b1;
            lhm_pkg::ST_CLEAR: mat_we  = 1'b1;
            lhm_pkg::ST_DLY_RD: dly_we = 1'b1;
            lhm_pkg::ST_MUL_LO: begin
                mul_a = {9'b0, d_reg[23:0]};
                mul_b = {1'b0, inv_width_reg};
            end
            lhm_pkg::ST_MUL_HI: begin
                mul_a = {{9{d_reg[VAL_W-1]}}, d_reg[VAL_W-1:24]};
                mul_b = {1'b0, inv_width_reg};
            end
            lhm_pkg::ST_CTR_MUL: begin
                mul_a = {1'b0, bin_width_reg};
                mul_b = {bc[31], bc};
            end
            lhm_pkg::ST_MODJ_GO: mod_req.start = 1'b1;
            lhm_pkg::ST_MODI_GO: begin
                mod_req.start = 1'b1;
                mod_req.value = bi_reg;
            end
            lhm_pkg::ST_MAT_RD: begin
                mat_raddr = {bi_reg[BIN_W-1:0], bj_reg[BIN_W-1:0]};
            end
            lhm_pkg::ST_MAT_INC: begin
                mat_we    = 1'b1;
                mat_waddr = {bi_reg[BIN_W-1:0], bj_reg[BIN_W-1:0]};
                mat_wdata = inc_val;
            end
            lhm_pkg::ST_SYM_RA: mat_raddr = {sym_i_reg, sym_j_reg};
            lhm_pkg::ST_SYM_RB: mat_raddr = {sym_j_reg, sym_i_reg};
            lhm_pkg::ST_SYM_WA: begin
                mat_we    = 1'b1;
                mat_waddr = {sym_i_reg, sym_j_reg};
                mat_wdata = sym_sum;
            end
            lhm_pkg::ST_SYM_WB: begin
                mat_we    = 1'b1;
                mat_waddr = {sym_j_reg, sym_i_reg};
                mat_wdata = sym_sum_reg;
            end
            default: begin
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lhm_pkg::ST_CLEAR;
            range_low_reg   <= lhm_pkg::RANGE_LOW_RST;
            bin_width_reg   <= lhm_pkg::BIN_WIDTH_RST;
            inv_width_reg   <= lhm_pkg::INV_WIDTH_RST;
            num_bins_reg    <= lhm_pkg::NUM_BINS_RST;
            lag_reg         <= lhm_pkg::LAG_RST;
            centre_mode_reg <= 1'b0;
            periodic_reg    <= 1'b0;
            dly_ptr_reg     <= '0;
            fill_reg        <= '0;
            clr_cnt_reg     <= '0;
            clr_cmd_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (lhm_pkg::cfg_reg_t'(cfg_index))
                    lhm_pkg::REG_RANGE_LOW:   range_low_reg   <= cfg_wdata;
                    lhm_pkg::REG_BIN_WIDTH:   bin_width_reg   <= cfg_wdata;
                    lhm_pkg::REG_INV_WIDTH:   inv_width_reg   <= cfg_wdata;
                    lhm_pkg::REG_NUM_BINS:    num_bins_reg    <= cfg_wdata[6:0];
                    lhm_pkg::REG_LAG:         lag_reg         <= cfg_wdata[10:0];
                    lhm_pkg::REG_CENTRE_MODE: centre_mode_reg <= cfg_wdata[0];
                    lhm_pkg::REG_PERIODIC:    periodic_reg    <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (s_accept) begin
                clr_cmd_reg <= 1'b1;
                if (s_cmd == lhm_pkg::CMD_NEW_TRAJ) begin
                    fill_reg    <= '0;
                    dly_ptr_reg <= '0;
                end
            end
            if (state_reg == lhm_pkg::ST_DLY_RD) begin
                if (LAG_W'(p_reg) + LAG_W'(1) >= lag_eff) begin
                    dly_ptr_reg <= '0;
                end else begin
                    dly_ptr_reg <= p_reg + PTR_W'(1);
                end
                if (filling) begin
                    fill_reg <= fill_reg + LAG_W'(1);
                end
            end
            if (state_reg == lhm_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + MAT_AW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            qi_reg     <= s_sample_value;
            xi_reg     <= s_include_flag;
            p_reg      <= p_comb;
            cnt_reg    <= '0;
            binned_reg <= 1'b0;
            phase_reg  <= 1'b0;
            sym_i_reg  <= '0;
            sym_j_reg  <= '0;
            rd_ok_reg  <= (int'(s_read_row) < MAX_BINS) && (int'(s_read_column) < MAX_BINS);
        end
        case (state_reg)
            lhm_pkg::ST_DLY_RD: begin
                diff_reg <= 33'(qi_reg) - 33'(qj);
                acc_reg  <= PROD_W'(qj) - PROD_W'(range_low_reg);
            end
            lhm_pkg::ST_DSAT:   d_reg  <= acc_clamp[VAL_W-1:0];
            lhm_pkg::ST_MUL_HI: lo_reg <= prod[55:0];
            lhm_pkg::ST_BIN: begin
                if (phase_reg) begin
                    bi_reg <= bin_val;
                end else begin
                    bj_reg    <= bin_val;
                    phase_reg <= 1'b1;
                    acc_reg   <= PROD_W'(qi_reg) - PROD_W'(range_low_reg);
                end
            end
            lhm_pkg::ST_CTR_ADD: begin
                // Offset of the current sample once the lagged one sits at
                // the centre of its bin; the low edge cancels out.
                acc_reg <= prod + $signed({35'b0, bin_width_reg[31:1]})
                           + PROD_W'(diff_reg);
            end
            lhm_pkg::ST_MODJ_WAIT: begin
                if (mod_rsp.done) begin
                    bj_reg <= $signed(VAL_W'(mod_rem));
                end
            end
            lhm_pkg::ST_MODI_WAIT: begin
                if (mod_rsp.done) begin
                    bi_reg <= $signed(VAL_W'(mod_rem));
                end
            end
            lhm_pkg::ST_MAT_INC: begin
                cnt_reg    <= inc_val;
                binned_reg <= 1'b1;
            end
            lhm_pkg::ST_RD_DATA: cnt_reg <= rd_ok_reg ? mat_rdata : '0;
            lhm_pkg::ST_SYM_RB:  sym_a_reg <= mat_rdata;
            lhm_pkg::ST_SYM_WA:  sym_sum_reg <= sym_sum;
            lhm_pkg::ST_SYM_WB: begin
                if (NB_W'(sym_j_reg) + NB_W'(1) == nb_eff) begin
                    sym_i_reg <= sym_i_reg + BIN_W'(1);
                    sym_j_reg <= sym_i_reg + BIN_W'(1);
                end else begin
                    sym_j_reg <= sym_j_reg + BIN_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_count_reg  <= cnt_reg;
            m_binned_reg <= binned_reg;
            m_cur_reg    <= binned_reg ? bi_reg[5:0] : 6'd0;
            m_lag_reg    <= binned_reg ? bj_reg[5:0] : 6'd0;
        end
    end

    lhm_ram #(
        .WIDTH (DLY_W),
        .DEPTH (MAX_LAG)
    ) u_delay_ram (
        .clk     (aclk),
        .wr_en   (dly_we),
        .wr_addr (dly_waddr),
        .wr_data (dly_wdata),
        .rd_addr (dly_raddr),
        .rd_data (dly_rdata)
    );

    lhm_ram #(
        .WIDTH (32),
        .DEPTH (MAT_DEPTH)
    ) u_matrix_ram (
        .clk     (aclk),
        .wr_en   (mat_we),
        .wr_addr (mat_waddr),
        .wr_data (mat_wdata),
        .rd_addr (mat_raddr),
        .rd_data (mat_rdata)
    );

    lhm_mul u_mul (
        .clk  (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    lhm_mod #(
        .NB_W (NB_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mod_req),
        .modulus   (nb_eff),
        .rsp       (mod_rsp),
        .remainder (mod_rem)
    );

    assign m_valid       = m_valid_reg;
    assign m_count       = m_count_reg;
    assign m_binned      = m_binned_reg;
    assign m_current_bin = m_cur_reg;
    assign m_lagged_bin  = m_lag_reg;

    // The remainder unit only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_rsp.busy |-> (state_reg == lhm_pkg::ST_MODJ_WAIT
                          || state_reg == lhm_pkg::ST_MODI_WAIT))
        else $error("remainder unit busy outside its wait states");

    // A binned word always reports a count of at least one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_binned) |-> (m_count != 32'd0))
        else $error("binned word with zero count");

    // Bins are reported only for binned words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_binned) |-> (m_current_bin == 6'd0 && m_lagged_bin == 6'd0))
        else $error("bin index on a word that was not binned");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // The scoreboard holds its own copy of the block's configuration,
    // delay line and count matrix. It computes the result of each
    // accepted input word and keeps it in a queue until the block
    // returns the matching result word.
    typedef struct packed {
        logic [31:0] count;
        logic        binned;
        logic [5:0]  current_bin;
        logic [5:0]  lagged_bin;
    } hist_result_t;

    class histogram_scoreboard;
        logic signed [31:0] range_low;
        logic [31:0]        bin_width;
        logic [31:0]        inverse_width;
        logic [6:0]         num_bins;
        logic [10:0]        lag;
        logic               centre_mode;
        logic               periodic;
        logic [31:0]        history_value [1024];
        logic               history_flag [1024];
        int unsigned        history_ptr;
        int unsigned        fill_level;
        logic [31:0]        counts [4096];
        hist_result_t       pending_results [$];
        int                 errors;

        function void reset_state();
            range_low     = lhm_pkg::RANGE_LOW_RST;
            bin_width     = lhm_pkg::BIN_WIDTH_RST;
            inverse_width = lhm_pkg::INV_WIDTH_RST;
            num_bins      = lhm_pkg::NUM_BINS_RST;
            lag           = lhm_pkg::LAG_RST;
            centre_mode   = 1'b0;
            periodic      = 1'b0;
            history_ptr   = 0;
            fill_level    = 0;
            foreach (counts[k]) counts[k] = '0;
            foreach (history_flag[k]) history_flag[k] = 1'b0;
            foreach (history_value[k]) history_value[k] = '0;
            pending_results.delete();
            errors        = 0;
        endfunction

        function void write_register(lhm_pkg::cfg_reg_t idx, logic [31:0] data);
            case (idx)
                lhm_pkg::REG_RANGE_LOW:   range_low = data;
                lhm_pkg::REG_BIN_WIDTH:   bin_width = data;
                lhm_pkg::REG_INV_WIDTH:   inverse_width = data;
                lhm_pkg::REG_NUM_BINS:    num_bins = data[6:0];
                lhm_pkg::REG_LAG:         lag = data[10:0];
                lhm_pkg::REG_CENTRE_MODE: centre_mode = data[0];
                lhm_pkg::REG_PERIODIC:    periodic = data[0];
                default: ;
            endcase
        endfunction

        function longint floor_shift16(longint x);
            return x >>> 16;
        endfunction

        // Integer part of (q - range_low) * inverse_width in Q32.32.
        function longint bin_index(longint q);
            longint d;
            longint hi;
            longint lo;
            d  = q - longint'(range_low);
            hi = longint'(inverse_width[31:16]);
            lo = longint'(inverse_width[15:0]);
            if (d > (64'sd1 <<< 46)) d = 64'sd1 <<< 46;
            if (d < -(64'sd1 <<< 46)) d = -(64'sd1 <<< 46);
            return floor_shift16(d * hi + floor_shift16(d * lo));
        endfunction

        function longint wrap_bin(longint b, longint n);
            longint r;
            r = b % n;
            return (r < 0) ? r + n : r;
        endfunction

        function void note_input(logic [2:0] cmd, logic signed [31:0] value, logic flag,
                                 logic [5:0] row, logic [5:0] col);
            hist_result_t res;
            int unsigned  eff_lag;
            longint       eff_bins;
            int unsigned  p;
            longint       old_value;
            logic         old_flag;
            longint       cur_bin;
            longint       lag_bin;
            longint       clamped;
            longint       centre;
            logic [32:0]  total;
            int unsigned  a;
            int unsigned  b;
            res = '0;
            eff_lag  = (lag == 0) ? 1 : (lag > 1024) ? 1024 : lag;
            eff_bins = (num_bins == 0) ? 1 : (num_bins > 64) ? 64 : num_bins;
            case (cmd)
                lhm_pkg::CMD_SAMPLE: begin
                    p = (history_ptr >= eff_lag) ? 0 : history_ptr;
                    old_value = longint'($signed(history_value[p]));
                    old_flag  = history_flag[p];
                    history_value[p] = value;
                    history_flag[p]  = flag;
                    history_ptr = (p + 1 >= eff_lag) ? 0 : p + 1;
                    if (fill_level < eff_lag) begin
                        fill_level++;
                    end else if (flag && old_flag) begin
                        lag_bin = bin_index(old_value);
                        if (centre_mode) begin
                            clamped = lag_bin;
                            if (clamped > (64'sd1 <<< 30)) clamped = 64'sd1 <<< 30;
                            if (clamped < -(64'sd1 <<< 30)) clamped = -(64'sd1 <<< 30);
                            centre = longint'(range_low) + longint'(bin_width) * clamped
                                     + longint'(bin_width >> 1);
                            cur_bin = bin_index(longint'(value) + centre - old_value);
                        end else begin
                            cur_bin = bin_index(longint'(value));
                        end
                        if (periodic) begin
                            cur_bin = wrap_bin(cur_bin, eff_bins);
                            lag_bin = wrap_bin(lag_bin, eff_bins);
                        end
                        if (cur_bin >= 0 && cur_bin < eff_bins &&
                            lag_bin >= 0 && lag_bin < eff_bins) begin
                            a = cur_bin * 64 + lag_bin;
                            if (counts[a] != 32'hFFFF_FFFF) counts[a]++;
                            res.count       = counts[a];
                            res.binned      = 1'b1;
                            res.current_bin = cur_bin[5:0];
                            res.lagged_bin  = lag_bin[5:0];
                        end
                    end
                end
                lhm_pkg::CMD_NEW_TRAJ: begin
                    fill_level  = 0;
                    history_ptr = 0;
                end
                lhm_pkg::CMD_SYMMETRIZE: begin
                    for (int i = 0; i < eff_bins; i++) begin
                        for (int j = i; j < eff_bins; j++) begin
                            a = i * 64 + j;
                            b = j * 64 + i;
                            total = {1'b0, counts[a]} + {1'b0, counts[b]};
                            counts[a] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                            counts[b] = counts[a];
                        end
                    end
                end
                lhm_pkg::CMD_READ: res.count = counts[row * 64 + col];
                lhm_pkg::CMD_CLEAR: foreach (counts[k]) counts[k] = '0;
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(hist_result_t got);
            hist_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word count=%h binned=%b cur=%0d lag=%0d",
                         $time, got.count, got.binned, got.current_bin, got.lagged_bin);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.count !== want.count) begin
                $display("%0t: count expected %h actual %h", $time, want.count, got.count);
                errors++;
            end
            if (got.binned !== want.binned) begin
                $display("%0t: binned expected %b actual %b", $time, want.binned, got.binned);
                errors++;
            end
            if (got.current_bin !== want.current_bin) begin
                $display("%0t: current_bin expected %0d actual %0d", $time,
                         want.current_bin, got.current_bin);
                errors++;
            end
            if (got.lagged_bin !== want.lagged_bin) begin
                $display("%0t: lagged_bin expected %0d actual %0d", $time,
                         want.lagged_bin, got.lagged_bin);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic signed [31:0] s_sample_value;
    logic               s_include_flag;
    logic [5:0]         s_read_row;
    logic [5:0]         s_read_column;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_count;
    logic               m_binned;
    logic [5:0]         m_current_bin;
    logic [5:0]         m_lagged_bin;

    lagged_transition_histogram dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_sample_value(s_sample_value),
        .s_include_flag(s_include_flag),
        .s_read_row    (s_read_row),
        .s_read_column (s_read_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count       (m_count),
        .m_binned      (m_binned),
        .m_current_bin (m_current_bin),
        .m_lagged_bin  (m_lagged_bin)
    );

    histogram_scoreboard board;

    // Idle percentages for the sender and the receiver, changed per phase.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned results_seen;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver drops m_ready at random. A result word is checked at the
    // edge where it is accepted, from values sampled before that edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_count, m_binned, m_current_bin, m_lagged_bin});
            results_seen++;
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Presents one input word, holding it until the block accepts it. The
    // expected result is computed at the accepting edge. Valid stays high
    // into the next word unless the sender decides to idle first.
    task automatic send_word(logic [2:0] cmd, logic [31:0] value, logic flag,
                             logic [5:0] row, logic [5:0] col);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_sample_value <= value;
        s_include_flag <= flag;
        s_read_row     <= row;
        s_read_column  <= col;
        do @(posedge aclk); while (!s_ready);
        board.note_input(cmd, value, flag, row, col);
    endtask

    task automatic send_sample(logic [31:0] value, logic flag);
        send_word(lhm_pkg::CMD_SAMPLE, value, flag, 6'($urandom), 6'($urandom));
    endtask

    // Waits for every outstanding result, then lets the block finish any
    // trailing work, such as a clear sweep.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (4200) @(posedge aclk);
    endtask

    // Configuration writes are made only while the block is drained.
    task automatic set_register(lhm_pkg::cfg_reg_t idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        board.write_register(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Picks a sample near the configured range most of the time, so that
    // pairs land in the matrix, and a wild value otherwise.
    function automatic logic [31:0] pick_value();
        longint span;
        if ($urandom_range(9) == 0) return $urandom;
        span = longint'(board.num_bins) * 65536;
        return board.range_low + 32'(longint'($urandom_range(32'(span + 131072))) - 65536);
    endfunction

    task automatic random_words(int n);
        int unsigned sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 80)
                send_sample(pick_value(), $urandom_range(9) != 0);
            else if (sel < 86)
                send_word(lhm_pkg::CMD_READ, $urandom, 1'($urandom), 6'($urandom),
                          6'($urandom));
            else if (sel < 90)
                send_word(lhm_pkg::CMD_NEW_TRAJ, $urandom, 1'($urandom), 6'd0, 6'd0);
            else if (sel < 93)
                send_word(lhm_pkg::CMD_SYMMETRIZE, $urandom, 1'($urandom), 6'd0, 6'd0);
            else if (sel < 95)
                send_word(lhm_pkg::CMD_CLEAR, $urandom, 1'($urandom), 6'd0, 6'd0);
            else if (sel < 97)
                send_word(3'($urandom_range(7, 5)), $urandom, 1'($urandom), 6'd0, 6'd0);
            else
                send_sample($urandom, 1'b1);
        end
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        board = new();
        board.reset_state();
        results_seen   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = lhm_pkg::REG_RANGE_LOW;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_cmd          = lhm_pkg::CMD_SAMPLE;
        s_sample_value = '0;
        s_include_flag = 1'b0;
        s_read_row     = '0;
        s_read_column  = '0;
        m_ready        = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: the delay line fills first, then
        // pairs are counted; extreme samples fall out of range and are
        // dropped; flags of zero block a pair; every command is exercised.
        send_sample(32'h0001_8000, 1'b1);
        send_sample(32'h0002_0000, 1'b1);
        send_sample(32'h0002_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h0003_0000, 1'b0);
        send_sample(32'h0003_0000, 1'b1);
        send_sample(32'h0003_0000, 1'b1);
        send_word(lhm_pkg::CMD_READ, 32'd0, 1'b0, 6'd2, 6'd1);
        send_word(lhm_pkg::CMD_SYMMETRIZE, 32'd0, 1'b0, 6'd0, 6'd0);
        send_word(lhm_pkg::CMD_READ, 32'd0, 1'b0, 6'd1, 6'd2);
        send_word(lhm_pkg::CMD_READ, 32'd0, 1'b0, 6'd63, 6'd63);
        send_word(lhm_pkg::CMD_NEW_TRAJ, 32'd0, 1'b0, 6'd0, 6'd0);
        send_sample(32'hFFFF_0000, 1'b1);
        send_word(3'd5, 32'd0, 1'b0, 6'd0, 6'd0);
        send_word(3'd7, 32'd0, 1'b0, 6'd0, 6'd0);
        send_word(lhm_pkg::CMD_CLEAR, 32'd0, 1'b0, 6'd0, 6'd0);
        send_word(lhm_pkg::CMD_READ, 32'd0, 1'b0, 6'd2, 6'd1);

        // The sender holds off until every result is back before any write.
        drain();
        set_register(lhm_pkg::REG_PERIODIC, 32'd1);
        set_register(lhm_pkg::REG_NUM_BINS, 32'd64);
        set_register(lhm_pkg::REG_LAG, 32'd0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'hFFFF_8000, 1'b1);
        send_sample(32'h0040_0000, 1'b1);

        // Random phases, each with its own settings and idling pattern.
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: begin
                    set_register(lhm_pkg::REG_RANGE_LOW, 32'hFFFE_0000);
                    set_register(lhm_pkg::REG_BIN_WIDTH, 32'h0000_8000);
                    set_register(lhm_pkg::REG_INV_WIDTH, 32'h0002_0000);
                    set_register(lhm_pkg::REG_NUM_BINS, 32'd16);
                    set_register(lhm_pkg::REG_LAG, 32'd3);
                    set_register(lhm_pkg::REG_CENTRE_MODE, 32'd1);
                    set_register(lhm_pkg::REG_PERIODIC, 32'd0);
                end
                1: begin
                    set_register(lhm_pkg::REG_NUM_BINS, 32'd1);
                    set_register(lhm_pkg::REG_LAG, 32'd1);
                    set_register(lhm_pkg::REG_CENTRE_MODE, 32'd0);
                    set_register(lhm_pkg::REG_PERIODIC, 32'd1);
                end
                2: begin
                    set_register(lhm_pkg::REG_RANGE_LOW, 32'h8000_0000);
                    set_register(lhm_pkg::REG_BIN_WIDTH, 32'hFFFF_FFFF);
                    set_register(lhm_pkg::REG_INV_WIDTH, 32'hFFFF_FFFF);
                    set_register(lhm_pkg::REG_NUM_BINS, 32'd127);
                    set_register(lhm_pkg::REG_LAG, 32'd2047);
                    set_register(lhm_pkg::REG_CENTRE_MODE, 32'd1);
                end
                3: begin
                    set_register(lhm_pkg::REG_RANGE_LOW, 32'h7FFF_FFFF);
                    set_register(lhm_pkg::REG_BIN_WIDTH, 32'd1);
                    set_register(lhm_pkg::REG_INV_WIDTH, 32'd0);
                    set_register(lhm_pkg::REG_NUM_BINS, 32'd0);
                    set_register(lhm_pkg::REG_LAG, 32'd1024);
                    set_register(lhm_pkg::REG_PERIODIC, 32'd0);
                end
                default: begin
                    set_register(lhm_pkg::REG_RANGE_LOW, $urandom);
                    set_register(lhm_pkg::REG_BIN_WIDTH, $urandom_range(32'h0002_0000, 1));
                    set_register(lhm_pkg::REG_INV_WIDTH, $urandom_range(32'h0004_0000));
                    set_register(lhm_pkg::REG_NUM_BINS, $urandom_range(64, 2));
                    set_register(lhm_pkg::REG_LAG, $urandom_range(6, 1));
                    set_register(lhm_pkg::REG_CENTRE_MODE, $urandom_range(1));
                    set_register(lhm_pkg::REG_PERIODIC, $urandom_range(1));
                end
            endcase
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(80, 0);
                2: set_idling(0, 80);
                default: set_idling(8, 8);
            endcase
            // A fresh trajectory after a lag change fills every delay entry
            // before the first pair is read.
            send_word(lhm_pkg::CMD_NEW_TRAJ, 32'd0, 1'b0, 6'd0, 6'd0);
            // The long-lag phases need their delay lines filled before pairs count.
            random_words(phase == 2 || phase == 3 ? 30 : 75);
            if (phase == 3) begin
                drain();
                set_register(lhm_pkg::REG_LAG, 32'd1);
                random_words(20);
            end
        end

        drain();
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lhm_pkg.sv
rtl/core/lhm_ram.sv
rtl/core/lhm_mul.sv
rtl/core/lhm_mod.sv
rtl/core/lagged_transition_histogram.sv
bench/tb_top.sv
